### src/dtc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared types and sizes for the decision tree classifier: table sizes,
// command codes, the queued item and the node table word.
// ----------------------------------------------------------------------------
package dtc_pkg;

    // Table sizes and walk bound
    localparam int MAX_NODES    = 1024;
    localparam int MAX_FEATURES = 64;
    localparam int MAX_DEPTH    = 32;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 10;
    localparam int VALUE_W = 32;
    localparam int FIDX_W  = 6;
    localparam int CLASS_W = 8;
    localparam int LEAF_W  = 16;

    // Derived widths
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int FEAT_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int STEP_W = $clog2(MAX_DEPTH + 1);

    // Command queue between front and back (power of two)
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Command codes on the input port
    localparam logic [CMD_W-1:0] CMD_WRITE_NODE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_FEAT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLASSIFY   = 2'd2;

    // Decoded operation of a queued item
    typedef enum logic [1:0] {
        OP_NODE,
        OP_FEAT,
        OP_CLASSIFY,
        OP_NONE
    } t_op;

    // Walk sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_NODE,
        S_FEAT,
        S_RESULT
    } t_state;

    // One item as it waits in the queue
    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  address;
        logic [VALUE_W-1:0] value;
        logic               is_leaf;
        logic [FIDX_W-1:0]  feature_index;
        logic [ADDR_W-1:0]  left_child;
        logic [ADDR_W-1:0]  right_child;
        logic [CLASS_W-1:0] class_code;
        logic [LEAF_W-1:0]  leaf_number;
    } t_item;

    // Queue head handed to the back part
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    // One node table word
    typedef struct packed {
        logic               is_leaf;
        logic [FIDX_W-1:0]  feature_index;
        logic [VALUE_W-1:0] threshold;
        logic [ADDR_W-1:0]  right_child;
        logic [ADDR_W-1:0]  left_child;
        logic [CLASS_W-1:0] class_code;
        logic [LEAF_W-1:0]  leaf_number;
    } t_node;

endpackage
`default_nettype wire

### src/dtc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_front
// Accepts items, decodes the command, drops unused commands and writes out
// of range, and holds the rest in a short queue for the back part.
// ----------------------------------------------------------------------------
module dtc_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [dtc_pkg::CMD_W-1:0]      i_command,
    input  wire logic [dtc_pkg::ADDR_W-1:0]     i_address,
    input  wire logic [dtc_pkg::VALUE_W-1:0]    i_value,
    input  wire logic                           i_is_leaf,
    input  wire logic [dtc_pkg::FIDX_W-1:0]     i_feature_index,
    input  wire logic [dtc_pkg::ADDR_W-1:0]     i_left_child,
    input  wire logic [dtc_pkg::ADDR_W-1:0]     i_right_child,
    input  wire logic [dtc_pkg::CLASS_W-1:0]    i_class_code,
    input  wire logic [dtc_pkg::LEAF_W-1:0]     i_leaf_number,
    output dtc_pkg::t_head                      o_head,
    input  wire logic                           i_pop
);

    dtc_pkg::t_item                    r_q [dtc_pkg::QDEPTH];
    logic [dtc_pkg::QPTR_W-1:0]        r_wr_ptr;
    logic [dtc_pkg::QPTR_W-1:0]        r_rd_ptr;
    logic [dtc_pkg::QCNT_W-1:0]        r_count;
    dtc_pkg::t_op                      op;
    logic                              keep;
    logic                              push;
    dtc_pkg::t_item                    item;

    // Decode the command
    always_comb begin
        unique case (i_command)
            dtc_pkg::CMD_WRITE_NODE: op = dtc_pkg::OP_NODE;
            dtc_pkg::CMD_WRITE_FEAT: op = dtc_pkg::OP_FEAT;
            dtc_pkg::CMD_CLASSIFY:   op = dtc_pkg::OP_CLASSIFY;
            default:                 op = dtc_pkg::OP_NONE;
        endcase
    end

    // Keep only items that change state or give a result
    always_comb begin
        case (op)
            dtc_pkg::OP_NODE:     keep = (32'(i_address) < dtc_pkg::MAX_NODES);
            dtc_pkg::OP_FEAT:     keep = (32'(i_address) < dtc_pkg::MAX_FEATURES);
            dtc_pkg::OP_CLASSIFY: keep = 1'b1;
            default:              keep = 1'b0;
        endcase
    end

    always_comb begin
        item.op            = op;
        item.address       = i_address;
        item.value         = i_value;
        item.is_leaf       = i_is_leaf;
        item.feature_index = i_feature_index;
        item.left_child    = i_left_child;
        item.right_child   = i_right_child;
        item.class_code    = i_class_code;
        item.leaf_number   = i_leaf_number;
    end

    assign o_stall = (r_count == dtc_pkg::QCNT_W'(dtc_pkg::QDEPTH));
    assign push    = i_valid && !o_stall && keep;

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head = {(r_count != '0), r_q[r_rd_ptr]};

`ifndef SYNTH
    // Never pop an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("dtc_front: pop from empty queue");

    // Fill level stays within the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dtc_pkg::QCNT_W'(dtc_pkg::QDEPTH))
        else $error("dtc_front: queue count overflow");

    // Never push into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_count != dtc_pkg::QCNT_W'(dtc_pkg::QDEPTH)))
        else $error("dtc_front: push into a full queue");
`endif

endmodule
`default_nettype wire

### src/dtc_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_walker
// Carries out queued items: writes the node table and feature store, walks
// the tree for a classify and holds the result in the output register.
// ----------------------------------------------------------------------------
module dtc_walker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  dtc_pkg::t_head                      i_head,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [dtc_pkg::CLASS_W-1:0]         o_result_class,
    output logic [dtc_pkg::LEAF_W-1:0]          o_result_leaf,
    output logic                                o_fault
);

    dtc_pkg::t_node                      node_mem [dtc_pkg::MAX_NODES];
    logic [dtc_pkg::VALUE_W-1:0]         feat_mem [dtc_pkg::MAX_FEATURES];

    dtc_pkg::t_state                     r_state;
    dtc_pkg::t_state                     n_state;
    dtc_pkg::t_node                      r_node_q;
    logic [dtc_pkg::VALUE_W-1:0]         r_feat_q;
    logic [dtc_pkg::STEP_W-1:0]          r_steps;
    logic [dtc_pkg::CLASS_W-1:0]         r_res_class;
    logic [dtc_pkg::LEAF_W-1:0]          r_res_leaf;
    logic                                r_res_fault;
    logic                                r_out_valid;
    logic [dtc_pkg::CLASS_W-1:0]         r_out_class;
    logic [dtc_pkg::LEAF_W-1:0]          r_out_leaf;
    logic                                r_out_fault;

    dtc_pkg::t_node                      wr_node;
    logic                                is_classify;
    logic                                depth_fault;
    logic                                fidx_fault;
    logic                                go_left;
    logic [dtc_pkg::ADDR_W-1:0]          next_node;
    logic                                child_fault;
    logic                                out_free;

    logic                                node_we;
    logic                                feat_we;
    logic                                node_rd_en;
    logic [dtc_pkg::NODE_W-1:0]          node_rd_addr;
    logic                                feat_rd_en;
    logic                                steps_clear;
    logic                                steps_inc;
    logic                                res_load;
    logic                                res_fault;
    logic                                out_load;

    // Walk decisions shared by both state machine blocks
    assign is_classify = i_head.valid && (i_head.item.op == dtc_pkg::OP_CLASSIFY);
    assign depth_fault = (r_steps >= dtc_pkg::STEP_W'(dtc_pkg::MAX_DEPTH));
    assign fidx_fault  = (32'(r_node_q.feature_index) >= dtc_pkg::MAX_FEATURES);
    assign go_left     = ($signed(r_feat_q) < $signed(r_node_q.threshold));
    assign next_node   = go_left ? r_node_q.left_child : r_node_q.right_child;
    assign child_fault = (32'(next_node) >= dtc_pkg::MAX_NODES);
    assign out_free    = !r_out_valid || !i_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dtc_pkg::S_IDLE: begin
                if (is_classify) begin
                    n_state = dtc_pkg::S_NODE;
                end
            end
            dtc_pkg::S_NODE: begin
                if (r_node_q.is_leaf || depth_fault || fidx_fault) begin
                    n_state = dtc_pkg::S_RESULT;
                end else begin
                    n_state = dtc_pkg::S_FEAT;
                end
            end
            dtc_pkg::S_FEAT: begin
                if (child_fault) begin
                    n_state = dtc_pkg::S_RESULT;
                end else begin
                    n_state = dtc_pkg::S_NODE;
                end
            end
            dtc_pkg::S_RESULT: begin
                if (out_free) begin
                    n_state = dtc_pkg::S_IDLE;
                end
            end
            default: n_state = dtc_pkg::S_IDLE;
        endcase
    end

    // State machine outputs
    always_comb begin
        o_pop        = 1'b0;
        node_we      = 1'b0;
        feat_we      = 1'b0;
        node_rd_en   = 1'b0;
        node_rd_addr = '0;
        feat_rd_en   = 1'b0;
        steps_clear  = 1'b0;
        steps_inc    = 1'b0;
        res_load     = 1'b0;
        res_fault    = 1'b0;
        out_load     = 1'b0;
        unique case (r_state)
            dtc_pkg::S_IDLE: begin
                o_pop = i_head.valid;
                if (i_head.valid) begin
                    node_we = (i_head.item.op == dtc_pkg::OP_NODE);
                    feat_we = (i_head.item.op == dtc_pkg::OP_FEAT);
                end
                if (is_classify) begin
                    node_rd_en  = 1'b1;
                    steps_clear = 1'b1;
                end
            end
            dtc_pkg::S_NODE: begin
                if (r_node_q.is_leaf) begin
                    res_load = 1'b1;
                end else if (depth_fault || fidx_fault) begin
                    res_load  = 1'b1;
                    res_fault = 1'b1;
                end else begin
                    feat_rd_en = 1'b1;
                end
            end
            dtc_pkg::S_FEAT: begin
                if (child_fault) begin
                    res_load  = 1'b1;
                    res_fault = 1'b1;
                end else begin
                    node_rd_en   = 1'b1;
                    node_rd_addr = next_node[dtc_pkg::NODE_W-1:0];
                    steps_inc    = 1'b1;
                end
            end
            dtc_pkg::S_RESULT: begin
                out_load = out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        wr_node.is_leaf       = i_head.item.is_leaf;
        wr_node.feature_index = i_head.item.feature_index;
        wr_node.threshold     = i_head.item.value;
        wr_node.right_child   = i_head.item.right_child;
        wr_node.left_child    = i_head.item.left_child;
        wr_node.class_code    = i_head.item.class_code;
        wr_node.leaf_number   = i_head.item.leaf_number;
    end

    // Node table: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[i_head.item.address[dtc_pkg::NODE_W-1:0]] <= wr_node;
        end
        if (node_rd_en) begin
            r_node_q <= node_mem[node_rd_addr];
        end
    end

    // Feature store: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (feat_we) begin
            feat_mem[i_head.item.address[dtc_pkg::FEAT_W-1:0]] <= i_head.item.value;
        end
        if (feat_rd_en) begin
            r_feat_q <= feat_mem[r_node_q.feature_index[dtc_pkg::FEAT_W-1:0]];
        end
    end

    // Hold the walk result until the output register takes it
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res_fault <= res_fault;
            r_res_class <= res_fault ? '0 : r_node_q.class_code;
            r_res_leaf  <= res_fault ? '0 : r_node_q.leaf_number;
        end
        if (out_load) begin
            r_out_class <= r_res_class;
            r_out_leaf  <= r_res_leaf;
            r_out_fault <= r_res_fault;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtc_pkg::S_IDLE;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (steps_clear) begin
                r_steps <= '0;
            end else if (steps_inc) begin
                r_steps <= r_steps + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_class = r_out_class;
    assign o_result_leaf  = r_out_leaf;
    assign o_fault        = r_out_fault;

`ifndef SYNTH
    // A faulted result carries zero class and leaf
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fault) |-> (r_out_class == '0 && r_out_leaf == '0))
        else $error("dtc_walker: fault result with nonzero fields");

    // The step count never passes the depth bound while walking
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtc_pkg::S_NODE) |-> (r_steps <= dtc_pkg::STEP_W'(dtc_pkg::MAX_DEPTH)))
        else $error("dtc_walker: step count beyond bound");

    // Items leave the queue only between walks
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == dtc_pkg::S_IDLE))
        else $error("dtc_walker: pop during a walk");

    // A loaded result appears on the output in the next cycle
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("dtc_walker: loaded result not presented");
`endif

endmodule
`default_nettype wire

### src/decision_tree_classifier_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// decision_tree_classifier_top
// Binary decision tree classifier with a loadable node table and feature
// vector.
// ----------------------------------------------------------------------------
// Node writes (command 0) and feature writes (command 1) are carried out
// in the back part; command 3 and writes beyond the tables are dropped at
// the input. A classify (command 2) walks from node 0, reading the node
// table and then the feature store, each a registered memory port, in turn
// for every tree level until a leaf or a fault gives the result. A two
// entry queue in front of the walker takes new items while a walk runs, and
// the result register lets the walker finish while the output is stalled.
// Faulted walks (step bound, feature slot or child beyond the table) give
// fault = 1 with zero class and leaf. Tables are not cleared at reset.
// ----------------------------------------------------------------------------
module decision_tree_classifier_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [dtc_pkg::CMD_W-1:0]      i_command,
    input  wire logic [dtc_pkg::ADDR_W-1:0]     i_address,
    input  wire logic [dtc_pkg::VALUE_W-1:0]    i_value,
    input  wire logic                           i_is_leaf,
    input  wire logic [dtc_pkg::FIDX_W-1:0]     i_feature_index,
    input  wire logic [dtc_pkg::ADDR_W-1:0]     i_left_child,
    input  wire logic [dtc_pkg::ADDR_W-1:0]     i_right_child,
    input  wire logic [dtc_pkg::CLASS_W-1:0]    i_class_code,
    input  wire logic [dtc_pkg::LEAF_W-1:0]     i_leaf_number,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [dtc_pkg::CLASS_W-1:0]         o_result_class,
    output logic [dtc_pkg::LEAF_W-1:0]          o_result_leaf,
    output logic                                o_fault
);

    dtc_pkg::t_head head;
    logic           pop;

    // Accept and queue items
    dtc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_address       (i_address),
        .i_value         (i_value),
        .i_is_leaf       (i_is_leaf),
        .i_feature_index (i_feature_index),
        .i_left_child    (i_left_child),
        .i_right_child   (i_right_child),
        .i_class_code    (i_class_code),
        .i_leaf_number   (i_leaf_number),
        .o_head          (head),
        .i_pop           (pop)
    );

    // Execute writes and walks
    dtc_walker u_walker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_class (o_result_class),
        .o_result_leaf  (o_result_leaf),
        .o_fault        (o_fault)
    );

endmodule
`default_nettype wire
